>>> rtl/core/dat_pkg.sv
// Shared types, constants and codes for the double-array trie lookup.
package dat_pkg;

    // Field widths fixed by the request format
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 12;
    localparam int BASE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 13;
    // Walk index: the root or a slot below slots_in_use, so it never needs more than the limit width
    localparam int IDX_W   = LIMIT_W;
    // Wide enough for a signed base plus a byte without overflow
    localparam int NEXT_W  = BASE_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    // Default table depth, reset values and queue depth
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int SLOTS_RST       = 4096;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_PREFIX = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOT  = 2'd0,
        REG_SLOTS = 2'd1,
        REG_TERM  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_CHECK
    } t_state;

    // One classified request in the queue between front and back
    typedef struct packed {
        t_cmd                     kind;
        logic [SLOT_W-1:0]        addr;
        logic signed [BASE_W-1:0] base;
        logic [BYTE_W-1:0]        byte_val;
    } t_qent;

    // Live configuration handed to the back end
    typedef struct packed {
        logic              root_load;
        logic [SLOT_W-1:0] root;
        logic [LIMIT_W-1:0] slots;
    } t_walk_cfg;

endpackage

>>> rtl/core/dat_in_if.sv
// Request channel: slot writes, key bytes and end-of-key commands.
interface dat_in_if;
    logic                               valid;
    logic                               ready;
    logic [dat_pkg::CMD_W-1:0]          cmd;
    logic [dat_pkg::SLOT_W-1:0]         slot_addr;
    logic signed [dat_pkg::BASE_W-1:0]  slot_base;
    logic [dat_pkg::BYTE_W-1:0]         slot_check;
    logic [dat_pkg::BYTE_W-1:0]         key_byte;

    modport source (output valid, cmd, slot_addr, slot_base, slot_check, key_byte,
                    input ready);
    modport sink   (input valid, cmd, slot_addr, slot_base, slot_check, key_byte,
                    output ready);
endinterface

>>> rtl/core/dat_out_if.sv
// Result channel: one result per end-of-key request.
interface dat_out_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [dat_pkg::BASE_W-1:0]  found_value;
    logic [dat_pkg::SLOT_W-1:0]         end_slot;

    modport source (output valid, found, found_value, end_slot, input ready);
    modport sink   (input valid, found, found_value, end_slot, output ready);
endinterface

>>> rtl/core/dat_queue.sv
// Short request queue between the front and back ends.
module dat_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dat_pkg::t_qent i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dat_pkg::t_qent o_data
);
    localparam int PTR_W = $clog2(dat_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dat_pkg::QUEUE_DEPTH + 1);

    dat_pkg::t_qent   r_mem [dat_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(dat_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(dat_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(dat_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> rtl/core/dat_front.sv
// Front end: accepts requests, drops out-of-range writes, fills in the terminator.
module dat_front #(
    parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
    dat_in_if.sink                     i_req,
    input  logic [dat_pkg::BYTE_W-1:0] i_term,
    input  logic                       i_q_full,
    output logic                       o_push,
    output dat_pkg::t_qent             o_ent
);
    logic w_accept, w_drop;

    assign i_req.ready = !i_q_full;
    assign w_accept    = i_req.valid && i_req.ready;
    // A write beyond the table has no effect and never reaches the back end
    assign w_drop      = (dat_pkg::t_cmd'(i_req.cmd) == dat_pkg::CMD_WRITE) &&
                         (dat_pkg::NEXT_W'(i_req.slot_addr) >= dat_pkg::NEXT_W'(TABLE_DEPTH));
    assign o_push      = w_accept && !w_drop;

    // Classify: a find steps on the terminator, a write carries its check byte
    always_comb begin
        o_ent.kind = dat_pkg::t_cmd'(i_req.cmd);
        o_ent.addr = i_req.slot_addr;
        o_ent.base = i_req.slot_base;
        unique case (dat_pkg::t_cmd'(i_req.cmd))
            dat_pkg::CMD_WRITE: o_ent.byte_val = i_req.slot_check;
            dat_pkg::CMD_FIND:  o_ent.byte_val = i_term;
            default:            o_ent.byte_val = i_req.key_byte;
        endcase
    end
endmodule

>>> rtl/core/dat_back.sv
// Back end: slot tables, walk sequencer and result register.
module dat_back #(
    parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dat_pkg::t_walk_cfg i_cfg,
    input  logic              i_q_valid,
    input  dat_pkg::t_qent    i_q_data,
    output logic              o_pop,
    dat_out_if.source         o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);

    // Slot tables
    logic [dat_pkg::BASE_W-1:0] r_base_mem  [TABLE_DEPTH];
    logic [dat_pkg::BYTE_W-1:0] r_check_mem [TABLE_DEPTH];

    dat_pkg::t_state             r_state, n_state;
    logic [dat_pkg::IDX_W-1:0]   r_idx;
    logic                        r_failed;
    dat_pkg::t_qent              r_cur;
    logic [dat_pkg::IDX_W-1:0]   r_next;
    logic [dat_pkg::BASE_W-1:0]  r_rd_base;
    logic [dat_pkg::BYTE_W-1:0]  r_rd_check;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [dat_pkg::BASE_W-1:0]  r_out_value;
    logic [dat_pkg::SLOT_W-1:0]  r_out_slot;

    logic                        w_out_free, w_idx_oob, w_in_range, w_check_ok;
    logic [dat_pkg::NEXT_W-1:0]  w_next;
    logic                        w_mem_we, w_rd_en, w_emit, w_walk_reset;
    logic                        w_set_fail, w_idx_load, w_cur_load, w_next_load;
    logic [AW-1:0]               w_rd_addr;
    logic                        w_emit_found;
    logic [dat_pkg::BASE_W-1:0]  w_emit_value;
    logic [dat_pkg::SLOT_W-1:0]  w_emit_slot;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_idx_oob  = dat_pkg::NEXT_W'(r_idx) >= dat_pkg::NEXT_W'(TABLE_DEPTH);
    // Candidate slot: sign-extended base plus the byte
    assign w_next     = {r_rd_base[dat_pkg::BASE_W-1], r_rd_base} +
                        dat_pkg::NEXT_W'(r_cur.byte_val);
    assign w_in_range = !w_next[dat_pkg::NEXT_W-1] &&
                        (w_next < dat_pkg::NEXT_W'(i_cfg.slots)) &&
                        (w_next < dat_pkg::NEXT_W'(TABLE_DEPTH));
    assign w_check_ok = (r_rd_check == r_cur.byte_val);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dat_pkg::ST_IDLE: begin
                if (w_rd_en) begin
                    n_state = dat_pkg::ST_BASE;
                end
            end
            dat_pkg::ST_BASE: begin
                if (w_in_range) begin
                    n_state = dat_pkg::ST_CHECK;
                end else if (r_cur.kind == dat_pkg::CMD_BYTE || w_out_free) begin
                    n_state = dat_pkg::ST_IDLE;
                end
            end
            dat_pkg::ST_CHECK: begin
                if (r_cur.kind == dat_pkg::CMD_BYTE || w_out_free) begin
                    n_state = dat_pkg::ST_IDLE;
                end
            end
            default: n_state = dat_pkg::ST_IDLE;
        endcase
    end

    // Sequencer actions
    always_comb begin
        o_pop        = 1'b0;
        w_mem_we     = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_emit       = 1'b0;
        w_emit_found = 1'b0;
        w_emit_value = '0;
        w_emit_slot  = '0;
        w_walk_reset = 1'b0;
        w_set_fail   = 1'b0;
        w_idx_load   = 1'b0;
        w_cur_load   = 1'b0;
        w_next_load  = 1'b0;
        unique case (r_state)
            dat_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_data.kind)
                        dat_pkg::CMD_WRITE: begin
                            o_pop    = 1'b1;
                            w_mem_we = 1'b1;
                        end
                        dat_pkg::CMD_BYTE: begin
                            o_pop = 1'b1;
                            if (!r_failed) begin
                                if (w_idx_oob) begin
                                    w_set_fail = 1'b1;
                                end else begin
                                    w_rd_en    = 1'b1;
                                    w_rd_addr  = AW'(r_idx);
                                    w_cur_load = 1'b1;
                                end
                            end
                        end
                        dat_pkg::CMD_FIND: begin
                            if (r_failed || w_idx_oob) begin
                                // Walk already dead: report failure at once
                                if (w_out_free) begin
                                    o_pop        = 1'b1;
                                    w_emit       = 1'b1;
                                    w_walk_reset = 1'b1;
                                end
                            end else begin
                                o_pop      = 1'b1;
                                w_rd_en    = 1'b1;
                                w_rd_addr  = AW'(r_idx);
                                w_cur_load = 1'b1;
                            end
                        end
                        dat_pkg::CMD_PREFIX: begin
                            if (w_out_free) begin
                                o_pop        = 1'b1;
                                w_emit       = 1'b1;
                                w_emit_found = !r_failed;
                                w_emit_slot  = r_failed ? '0 : r_idx[dat_pkg::SLOT_W-1:0];
                                w_walk_reset = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dat_pkg::ST_BASE: begin
                if (w_in_range) begin
                    // Fetch check and base of the candidate slot together
                    w_rd_en     = 1'b1;
                    w_rd_addr   = AW'(w_next[dat_pkg::IDX_W-1:0]);
                    w_next_load = 1'b1;
                end else if (r_cur.kind == dat_pkg::CMD_BYTE) begin
                    w_set_fail = 1'b1;
                end else if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_walk_reset = 1'b1;
                end
            end
            dat_pkg::ST_CHECK: begin
                if (r_cur.kind == dat_pkg::CMD_BYTE) begin
                    w_idx_load = w_check_ok;
                    w_set_fail = !w_check_ok;
                end else if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_emit_found = w_check_ok;
                    w_emit_value = w_check_ok ? r_rd_base : '0;
                    w_emit_slot  = w_check_ok ? r_next[dat_pkg::SLOT_W-1:0] : '0;
                    w_walk_reset = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Table write port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_base_mem[AW'(i_q_data.addr)]  <= i_q_data.base;
            r_check_mem[AW'(i_q_data.addr)] <= i_q_data.byte_val;
        end
    end

    // Table read port, registered data
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_base  <= r_base_mem[w_rd_addr];
            r_rd_check <= r_check_mem[w_rd_addr];
        end
    end

    // Current request and candidate slot
    always_ff @(posedge i_clk) begin
        if (w_cur_load) begin
            r_cur <= i_q_data;
        end
        if (w_next_load) begin
            r_next <= w_next[dat_pkg::IDX_W-1:0];
        end
        if (w_emit) begin
            r_out_found <= w_emit_found;
            r_out_value <= w_emit_value;
            r_out_slot  <= w_emit_slot;
        end
    end

    // Control state: sequencer, walk position, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dat_pkg::ST_IDLE;
            r_idx       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.root_load) begin
                r_idx    <= dat_pkg::IDX_W'(i_cfg.root);
                r_failed <= 1'b0;
            end else if (w_walk_reset) begin
                r_idx    <= dat_pkg::IDX_W'(i_cfg.root);
                r_failed <= 1'b0;
            end else if (w_idx_load) begin
                r_idx <= r_next;
            end else if (w_set_fail) begin
                r_failed <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.found_value = r_out_value;
    assign o_rsp.end_slot    = r_out_slot;
endmodule

>>> rtl/core/double_array_trie_lookup.sv
// Top level of the double-array trie lookup: configuration, front, queue, back.
//
//  Channel   Dir  Handshake           Moves
//  i_req     in   valid/ready         slot write, key byte, end as find, end as prefix
//  o_rsp     out  valid/ready         found, found_value, end_slot
//  i_cfg_*   in   write enable only   root_slot, slots_in_use, terminator_byte
//
//  A key byte or a find whose derived slot is in range passes the back end in order:
//  the base read at the current slot, then the check and base read at the derived
//  slot, then the compare. One whose derived slot is out of range stops after the base
//  read. Slot writes, prefix ends, and bytes or finds of an already failed key end in idle.
//  A two-entry request queue lets the front accept while the back works.
//  Reset is synchronous; the slot tables are not cleared and need no clearing pass.
//  A result waiting in the output register holds the back end at the next
//  end-of-key request; the queue then fills behind it.
module double_array_trie_lookup #(
    parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dat_in_if.sink                         i_req,
    dat_out_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [dat_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dat_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [dat_pkg::SLOT_W-1:0]  r_root;
    logic [dat_pkg::LIMIT_W-1:0] r_slots;
    logic [dat_pkg::BYTE_W-1:0]  r_term;
    dat_pkg::t_walk_cfg          w_cfg;
    logic                        w_push, w_pop, w_q_full, w_q_valid;
    dat_pkg::t_qent              w_push_ent, w_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_slots <= dat_pkg::LIMIT_W'(dat_pkg::SLOTS_RST);
            r_term  <= '0;
        end else if (i_cfg_we) begin
            case (dat_pkg::t_cfg_reg'(i_cfg_idx))
                dat_pkg::REG_ROOT:  r_root  <= i_cfg_data[dat_pkg::SLOT_W-1:0];
                dat_pkg::REG_SLOTS: r_slots <= i_cfg_data;
                dat_pkg::REG_TERM:  r_term  <= i_cfg_data[dat_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // A root write restarts the walk
    always_comb begin
        w_cfg.root_load = i_cfg_we && (dat_pkg::t_cfg_reg'(i_cfg_idx) == dat_pkg::REG_ROOT);
        w_cfg.root      = w_cfg.root_load ? i_cfg_data[dat_pkg::SLOT_W-1:0] : r_root;
        w_cfg.slots     = r_slots;
    end

    dat_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_req    (i_req),
        .i_term   (r_term),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_ent    (w_push_ent)
    );

    dat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ent),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head)
    );

    dat_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_head),
        .o_pop     (w_pop),
        .o_rsp     (o_rsp)
    );
endmodule

>>> rtl/core/dat_checker.sv
// Port-level checks on the trie lookup, bound to the top level.
module dat_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic                              i_found,
    input logic signed [dat_pkg::BASE_W-1:0] i_found_value,
    input logic [dat_pkg::SLOT_W-1:0]        i_end_slot
);
    // No result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    // A failed walk reports zero value and zero slot
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_found) |-> (i_found_value == '0 && i_end_slot == '0))
        else $error("failed result carries non-zero fields");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_found) && $stable(i_found_value) &&
             $stable(i_end_slot)))
        else $error("stalled result changed");
endmodule

bind double_array_trie_lookup dat_checker u_dat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_found_value (o_rsp.found_value),
    .i_end_slot    (o_rsp.end_slot)
);

>>> verif/tb.sv
// Testbench for the double-array trie lookup: shadow-table walk prediction under random idling.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH        = dat_pkg::TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [dat_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                              found;
        logic signed [dat_pkg::BASE_W-1:0] value;
        logic [dat_pkg::SLOT_W-1:0]        slot;
    } t_lookup_res;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [dat_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [dat_pkg::CFG_DATA_W-1:0] cfg_data;

    dat_in_if  req_if ();
    dat_out_if rsp_if ();

    double_array_trie_lookup #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the tables, the walk and the registers
    logic signed [dat_pkg::BASE_W-1:0] base_shadow  [DEPTH];
    logic [dat_pkg::BYTE_W-1:0]        check_shadow [DEPTH];
    bit                                slot_written [DEPTH];
    logic [dat_pkg::SLOT_W-1:0]        walk_at;
    logic                              walk_dead;
    logic [dat_pkg::SLOT_W-1:0]        root_cfg;
    logic [dat_pkg::LIMIT_W-1:0]       slots_cfg;
    logic [dat_pkg::BYTE_W-1:0]        term_cfg;
    bit                                in_trie [DEPTH];

    t_lookup_res pending_lookups [$];
    int          fail_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: too long without any handshake or register write
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result checker: compare each accepted result with the oldest pending lookup
    always @(posedge i_clk) begin : check_results
        t_lookup_res want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_lookups.size() == 0) begin
                $error("result with no lookup pending: found=%0b value=%0d slot=%0d",
                       rsp_if.found, rsp_if.found_value, rsp_if.end_slot);
                fail_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_if.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, rsp_if.found);
                    fail_count++;
                end
                if (rsp_if.found_value !== want.value) begin
                    $error("found_value: expected %0d, got %0d", want.value, rsp_if.found_value);
                    fail_count++;
                end
                if (rsp_if.end_slot !== want.slot) begin
                    $error("end_slot: expected %0d, got %0d", want.slot, rsp_if.end_slot);
                    fail_count++;
                end
            end
        end
    end

    function automatic int usable_limit();
        return (int'(slots_cfg) < DEPTH) ? int'(slots_cfg) : DEPTH;
    endfunction

    // One trie step on a byte; a dead walk stays dead until the key ends
    function automatic void advance_walk(logic [dat_pkg::BYTE_W-1:0] step_byte);
        longint target;
        if (walk_dead) return;
        target = longint'(base_shadow[walk_at]) + longint'(step_byte);
        if (target < 0 || target >= usable_limit()) walk_dead = 1'b1;
        else if (check_shadow[target[dat_pkg::SLOT_W-1:0]] != step_byte) walk_dead = 1'b1;
        else walk_at = target[dat_pkg::SLOT_W-1:0];
    endfunction

    // Apply one accepted request to the shadow state; end-of-key queues a lookup result
    function automatic void predict_request(dat_pkg::t_cmd cmd,
                                            logic [dat_pkg::SLOT_W-1:0] addr,
                                            logic signed [dat_pkg::BASE_W-1:0] sbase,
                                            logic [dat_pkg::BYTE_W-1:0] schk,
                                            logic [dat_pkg::BYTE_W-1:0] kbyte);
        t_lookup_res res;
        case (cmd)
            dat_pkg::CMD_WRITE: begin
                base_shadow[addr]  = sbase;
                check_shadow[addr] = schk;
                slot_written[addr] = 1'b1;
            end
            dat_pkg::CMD_BYTE: advance_walk(kbyte);
            default: begin
                if (cmd == dat_pkg::CMD_FIND) advance_walk(term_cfg);
                res = '0;
                if (!walk_dead) begin
                    res.found = 1'b1;
                    res.value = (cmd == dat_pkg::CMD_FIND) ? base_shadow[walk_at] : '0;
                    res.slot  = walk_at;
                end
                pending_lookups.push_back(res);
                walk_at   = root_cfg;
                walk_dead = 1'b0;
            end
        endcase
    endfunction

    // Send one request, with an optional idle gap first
    task automatic send_req(dat_pkg::t_cmd cmd, logic [dat_pkg::SLOT_W-1:0] addr,
                            logic signed [dat_pkg::BASE_W-1:0] sbase,
                            logic [dat_pkg::BYTE_W-1:0] schk,
                            logic [dat_pkg::BYTE_W-1:0] kbyte);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < src_idle_pct);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.slot_addr  <= addr;
        req_if.slot_base  <= sbase;
        req_if.slot_check <= schk;
        req_if.key_byte   <= kbyte;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        predict_request(cmd, addr, sbase, schk, kbyte);
    endtask

    task automatic send_write(logic [dat_pkg::SLOT_W-1:0] addr,
                              logic signed [dat_pkg::BASE_W-1:0] sbase,
                              logic [dat_pkg::BYTE_W-1:0] schk);
        send_req(dat_pkg::CMD_WRITE, addr, sbase, schk, dat_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_byte(logic [dat_pkg::BYTE_W-1:0] kbyte);
        send_req(dat_pkg::CMD_BYTE, dat_pkg::SLOT_W'($urandom), dat_pkg::BASE_W'($urandom),
                 dat_pkg::BYTE_W'($urandom), kbyte);
    endtask

    task automatic send_end(dat_pkg::t_cmd cmd);
        send_req(cmd, dat_pkg::SLOT_W'($urandom), dat_pkg::BASE_W'($urandom),
                 dat_pkg::BYTE_W'($urandom), dat_pkg::BYTE_W'($urandom));
    endtask

    // Hold requests until every lookup has returned and the back end has settled
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dat_pkg::CFG_IDX_W-1:0] idx,
                             logic [dat_pkg::CFG_DATA_W-1:0] val);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            dat_pkg::REG_ROOT: begin
                root_cfg  = val[dat_pkg::SLOT_W-1:0];
                walk_at   = root_cfg;
                walk_dead = 1'b0;
            end
            dat_pkg::REG_SLOTS: slots_cfg = val;
            dat_pkg::REG_TERM:  term_cfg  = val[dat_pkg::BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly a base that puts children inside the limit; now and then any word
    function automatic logic signed [dat_pkg::BASE_W-1:0] pick_base(int lim, bit wild);
        if (wild && $urandom_range(15) == 0) return dat_pkg::BASE_W'($urandom);
        return dat_pkg::BASE_W'(int'($urandom_range(lim - 1)) - int'($urandom_range(255)));
    endfunction

    // Load the slot that a step on this byte would read, if it is in range and still empty
    task automatic cover_step(logic [dat_pkg::BYTE_W-1:0] step_byte, inout int n_sent);
        longint target;
        if (walk_dead) return;
        target = longint'(base_shadow[walk_at]) + longint'(step_byte);
        if (target >= 0 && target < usable_limit() &&
            !slot_written[target[dat_pkg::SLOT_W-1:0]]) begin
            send_write(target[dat_pkg::SLOT_W-1:0], pick_base(usable_limit(), 1'b1),
                       dat_pkg::BYTE_W'($urandom));
            n_sent++;
        end
    endtask

    // Next key byte: usually one with a live child, otherwise anything
    function automatic logic [dat_pkg::BYTE_W-1:0] pick_key_byte();
        logic [dat_pkg::BYTE_W-1:0] live [$];
        longint target;
        if (!walk_dead && $urandom_range(9) != 0) begin
            for (int b = 0; b < 256; b++) begin
                target = longint'(base_shadow[walk_at]) + longint'(b);
                if (target >= 0 && target < usable_limit() &&
                    slot_written[target[dat_pkg::SLOT_W-1:0]] &&
                    check_shadow[target[dat_pkg::SLOT_W-1:0]] == dat_pkg::BYTE_W'(b))
                    live.push_back(dat_pkg::BYTE_W'(b));
            end
            if (live.size() != 0) return live[$urandom_range(live.size() - 1)];
        end
        return dat_pkg::BYTE_W'($urandom);
    endfunction

    // Grow a random trie from the current root, one child slot per write
    task automatic build_trie(int n_nodes);
        logic [dat_pkg::SLOT_W-1:0] nodes [$];
        logic [dat_pkg::SLOT_W-1:0] parent;
        logic [dat_pkg::BYTE_W-1:0] edge_byte;
        longint                     child;
        int                         lim;
        lim = usable_limit();
        foreach (in_trie[s]) in_trie[s] = 1'b0;
        in_trie[root_cfg] = 1'b1;
        nodes.push_back(root_cfg);
        send_write(root_cfg, pick_base(lim, 1'b0), dat_pkg::BYTE_W'($urandom));
        for (int tries = 0; tries < 8 * n_nodes && nodes.size() < n_nodes; tries++) begin
            parent    = nodes[$urandom_range(nodes.size() - 1)];
            edge_byte = ($urandom_range(3) == 0) ? term_cfg : dat_pkg::BYTE_W'($urandom);
            child     = longint'(base_shadow[parent]) + longint'(edge_byte);
            if (child >= 0 && child < lim && !in_trie[child[dat_pkg::SLOT_W-1:0]]) begin
                in_trie[child[dat_pkg::SLOT_W-1:0]] = 1'b1;
                nodes.push_back(child[dat_pkg::SLOT_W-1:0]);
                send_write(child[dat_pkg::SLOT_W-1:0], pick_base(lim, 1'b1), edge_byte);
            end
        end
    endtask

    // Hand-built trie at root 0: base extremes, wrong check, negative index, empty keys
    task automatic test_directed_walks();
        send_write(12'd0,    32'sd100,         8'hFF);
        send_write(12'd105,  32'sh7FFF_FFFF,   8'd5);
        send_write(12'd110,  32'sh8000_0000,   8'd10);
        send_write(12'd100,  -32'sd1234,       8'd0);
        send_write(12'd355,  32'sd3841,        8'd255);
        send_write(12'd3841, 32'sh8000_0000,   8'd0);
        send_write(12'd106,  32'sd0,           8'd7);
        // terminator step from the largest base runs off the table
        send_byte(8'd5);
        send_end(dat_pkg::CMD_FIND);
        send_byte(8'd5);
        send_end(dat_pkg::CMD_PREFIX);
        // negative index, then further bytes on a dead walk
        send_byte(8'd10);
        send_byte(8'd255);
        send_byte(8'd0);
        send_end(dat_pkg::CMD_PREFIX);
        // empty key find hits the root's terminator child
        send_end(dat_pkg::CMD_FIND);
        send_byte(8'd255);
        send_end(dat_pkg::CMD_FIND);
        // check byte mismatch
        send_byte(8'd6);
        send_end(dat_pkg::CMD_PREFIX);
        send_end(dat_pkg::CMD_PREFIX);
    endtask

    // Slot limit at zero and around the terminator slot, highest terminator byte
    task automatic test_config_edges();
        write_reg(dat_pkg::REG_SLOTS, '0);
        send_end(dat_pkg::CMD_FIND);
        send_end(dat_pkg::CMD_PREFIX);
        send_byte(8'd5);
        send_end(dat_pkg::CMD_PREFIX);
        write_reg(dat_pkg::REG_SLOTS, 13'd101);
        send_end(dat_pkg::CMD_FIND);
        write_reg(dat_pkg::REG_SLOTS, 13'd100);
        send_end(dat_pkg::CMD_FIND);
        write_reg(dat_pkg::REG_SLOTS, 13'(dat_pkg::SLOTS_RST));
        write_reg(dat_pkg::REG_TERM, 13'd255);
        send_end(dat_pkg::CMD_FIND);
        write_reg(dat_pkg::REG_TERM, '0);
    endtask

    // Root past the limit, root write mid-key, write to an unused register index
    task automatic test_root_change();
        write_reg(dat_pkg::REG_SLOTS, 13'd1);
        write_reg(dat_pkg::REG_ROOT, 13'd4095);
        send_write(12'd4095, -32'sd5, 8'd0);
        send_write(12'd0, 32'sd100, 8'd5);
        send_end(dat_pkg::CMD_PREFIX);
        send_byte(8'd5);
        send_end(dat_pkg::CMD_PREFIX);
        send_byte(8'd5);
        write_reg(dat_pkg::REG_ROOT, 13'd4095);
        send_end(dat_pkg::CMD_PREFIX);
        send_byte(8'd5);
        write_reg(REG_UNUSED, 13'h1FFF);
        send_end(dat_pkg::CMD_PREFIX);
    endtask

    // Fresh trie under one setting, then mostly well-formed keys with some noise
    task automatic test_random_lookups(int src_pct, int sink_pct,
                                       logic [dat_pkg::SLOT_W-1:0] root,
                                       logic [dat_pkg::LIMIT_W-1:0] slots,
                                       logic [dat_pkg::BYTE_W-1:0] term,
                                       int n_items);
        int                         sent;
        int                         key_len;
        logic [dat_pkg::BYTE_W-1:0] kbyte;
        dat_pkg::t_cmd              req_cmd;
        write_reg(dat_pkg::REG_ROOT, dat_pkg::CFG_DATA_W'(root));
        write_reg(dat_pkg::REG_SLOTS, slots);
        write_reg(dat_pkg::REG_TERM, dat_pkg::CFG_DATA_W'(term));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        build_trie(48);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) != 0) begin
                key_len = $urandom_range(6);
                repeat (key_len) begin
                    kbyte = pick_key_byte();
                    cover_step(kbyte, sent);
                    send_byte(kbyte);
                end
                req_cmd = $urandom_range(1) ? dat_pkg::CMD_FIND : dat_pkg::CMD_PREFIX;
                if (req_cmd == dat_pkg::CMD_FIND) cover_step(term_cfg, sent);
                send_end(req_cmd);
                sent += key_len + 1;
            end else begin
                req_cmd = dat_pkg::t_cmd'(2'($urandom_range(3)));
                kbyte   = dat_pkg::BYTE_W'($urandom);
                if (req_cmd == dat_pkg::CMD_BYTE) cover_step(kbyte, sent);
                else if (req_cmd == dat_pkg::CMD_FIND) cover_step(term_cfg, sent);
                send_req(req_cmd, dat_pkg::SLOT_W'($urandom), dat_pkg::BASE_W'($urandom),
                         dat_pkg::BYTE_W'($urandom), kbyte);
                sent++;
            end
            // now and then hold off until every lookup is back
            if ($urandom_range(63) == 0) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_lookups.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    // Sequence
    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_data          <= '0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= dat_pkg::CMD_WRITE;
        req_if.slot_addr  <= '0;
        req_if.slot_base  <= '0;
        req_if.slot_check <= '0;
        req_if.key_byte   <= '0;
        root_cfg       = '0;
        slots_cfg      = dat_pkg::LIMIT_W'(dat_pkg::SLOTS_RST);
        term_cfg       = '0;
        walk_at        = '0;
        walk_dead      = 1'b0;
        fail_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_walks();
        test_config_edges();
        test_root_change();
        test_random_lookups(0, 0, 12'd0, 13'(dat_pkg::SLOTS_RST), 8'd0, 175);
        test_random_lookups(87, 0, 12'd4095, 13'($urandom_range(4096, 2000)), 8'd255, 175);
        test_random_lookups(0, 87, dat_pkg::SLOT_W'($urandom), 13'($urandom_range(1024, 256)),
                            dat_pkg::BYTE_W'($urandom), 175);
        test_random_lookups(32, 32, dat_pkg::SLOT_W'($urandom), 13'(dat_pkg::SLOTS_RST),
                            dat_pkg::BYTE_W'($urandom), 175);

        wait_drain();
        if (fail_count == 0 && pending_lookups.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
